// ----- rtl/service_rule_classifier_macros.svh -----
// Assertion macros for the checker file of the rule classifier.
`ifndef SERVICE_RULE_CLASSIFIER_MACROS_SVH
`define SERVICE_RULE_CLASSIFIER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/src_pkg.sv -----
// Types and constants shared by the rule classifier modules.
`default_nettype none

package src_pkg;

  localparam logic [1:0] CMD_CLASSIFY  = 2'd0;
  localparam logic [1:0] CMD_WR_PROTO  = 2'd1;
  localparam logic [1:0] CMD_WR_SRC    = 2'd2;
  localparam logic [1:0] CMD_WR_DST    = 2'd3;

  localparam logic [7:0] PROTO_ICMP    = 8'd1;

  // Empty range after reset: low above high.
  localparam logic [15:0] EMPTY_LOW    = 16'd1;
  localparam logic [15:0] EMPTY_HIGH   = 16'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  rule_index;
    logic [1:0]  range_slot;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [7:0]  protocol;
    logic [15:0] first_port;
    logic [15:0] second_port;
    logic        syn_only;
  } req_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  rule_number;
    logic        swapped;
    logic [15:0] server_port;
    logic [15:0] client_port;
  } rsp_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic valid;
    rsp_t res;
  } token_t;

  typedef struct packed {
    logic       load_go;
    logic [4:0] rule_count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/src_rule_cell.sv -----
// One rule of the table: its protocol and port sets, and one search step.
`default_nettype none

module src_rule_cell
  import src_pkg::*;
#(
  parameter int IDX            = 0,
  parameter int RANGES_PER_SET = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire req_t       query,
  input  wire token_t     tin,
  output token_t          tout
);

  localparam logic [31:0] IDX_W    = 32'(IDX);
  localparam logic [3:0]  RULE_NUM = IDX_W[3:0];

  logic [7:0]  proto;
  logic [15:0] src_lo [RANGES_PER_SET];
  logic [15:0] src_hi [RANGES_PER_SET];
  logic [15:0] dst_lo [RANGES_PER_SET];
  logic [15:0] dst_hi [RANGES_PER_SET];

  logic sel;
  logic src_p0, dst_p0, src_p1, dst_p1;
  logic active, proto_eq, way_ok, hit, swap;

  assign sel = ctrl.load_go && (32'(query.rule_index) == IDX_W);

  // Load commands land here in the cycle after the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      proto <= '0;
      for (int k = 0; k < RANGES_PER_SET; k++) begin
        src_lo[k] <= EMPTY_LOW;
        src_hi[k] <= EMPTY_HIGH;
        dst_lo[k] <= EMPTY_LOW;
        dst_hi[k] <= EMPTY_HIGH;
      end
    end else if (sel) begin
      if (query.cmd == CMD_WR_PROTO) begin
        proto <= query.protocol;
      end
      for (int k = 0; k < RANGES_PER_SET; k++) begin
        if (32'(query.range_slot) == 32'(k)) begin
          if (query.cmd == CMD_WR_SRC) begin
            src_lo[k] <= query.range_low;
            src_hi[k] <= query.range_high;
          end
          if (query.cmd == CMD_WR_DST) begin
            dst_lo[k] <= query.range_low;
            dst_hi[k] <= query.range_high;
          end
        end
      end
    end
  end

  always_comb begin
    src_p0 = 1'b0;
    dst_p0 = 1'b0;
    src_p1 = 1'b0;
    dst_p1 = 1'b0;
    for (int k = 0; k < RANGES_PER_SET; k++) begin
      src_p0 = src_p0 | ((query.first_port  >= src_lo[k]) && (query.first_port  <= src_hi[k]));
      dst_p0 = dst_p0 | ((query.first_port  >= dst_lo[k]) && (query.first_port  <= dst_hi[k]));
      src_p1 = src_p1 | ((query.second_port >= src_lo[k]) && (query.second_port <= src_hi[k]));
      dst_p1 = dst_p1 | ((query.second_port >= dst_lo[k]) && (query.second_port <= dst_hi[k]));
    end
  end

  assign active   = 32'(ctrl.rule_count) > IDX_W;
  assign proto_eq = proto == query.protocol;

  // First port in the source set: reverse way only, blocked by a bare SYN.
  // Otherwise the forward way, never for ICMP.
  always_comb begin
    if (src_p0) begin
      way_ok = dst_p1 && !query.syn_only;
    end else if (dst_p0) begin
      way_ok = (query.protocol != PROTO_ICMP) && src_p1;
    end else begin
      way_ok = 1'b0;
    end
  end

  assign hit  = active && proto_eq && way_ok;
  assign swap = src_p0 && (query.protocol != PROTO_ICMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
  end

  // Claim the token on the first hit; pass it on untouched otherwise.
  always_ff @(posedge clk) begin
    if (tin.valid && !tin.res.matched && hit) begin
      tout.res.matched     <= 1'b1;
      tout.res.rule_number <= RULE_NUM;
      tout.res.swapped     <= swap;
      tout.res.server_port <= swap ? query.second_port : query.first_port;
      tout.res.client_port <= swap ? query.first_port  : query.second_port;
    end else begin
      tout.res <= tin.res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/service_rule_classifier.sv -----
// Usage of the service rule classifier.
// A request on req (req_valid / req_stall) either loads one field of a rule
// (protocol, or one source or destination port range) or classifies a stream.
// A load gives no result. A classify request walks a
// token down a row of RULE_SLOTS cells, one rule per cycle; the first rule
// that hits claims the token. Its result reaches rsp through the start
// register, the cell row and the rsp register; a new request is taken only
// once the token of the previous classify leaves the last cell.
// The cfg channel (cfg_valid / cfg_ready) writes the number of rules searched;
// write it only while no classify is in flight.
// Reset empties every rule, sets the rule count to zero and drops any result.
// While rsp_stall is high the result holds on rsp; one further result can be
// parked inside, after which req_stall rises until rsp drains.
`default_nettype none

module service_rule_classifier
  import src_pkg::*;
#(
  parameter int RULE_SLOTS     = 16,
  parameter int RANGES_PER_SET = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);

  logic       req_acc, is_classify;
  logic       searching, start, load_go, pend_valid;
  logic [4:0] rule_count;
  req_t       cur;
  rsp_t       pend;
  logic       rsp_free;
  token_t     head;
  token_t     chain [RULE_SLOTS];
  token_t     last;
  cell_ctrl_t ctrl;

  assign is_classify = req.cmd == CMD_CLASSIFY;
  assign req_acc     = req_valid && !req_stall;
  assign last        = chain[RULE_SLOTS-1];
  // Hold requests while a classify is in the row, or while a finished result has to be parked or is parked.
  assign req_stall   = (searching && !last.valid) || pend_valid || (last.valid && !rsp_free);
  assign cfg_ready   = !searching;
  assign rsp_free    = !rsp_valid || !rsp_stall;

  assign head.valid = start;
  assign head.res   = '0;

  assign ctrl.load_go    = load_go;
  assign ctrl.rule_count = rule_count;

  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      src_rule_cell #(
        .IDX            (i),
        .RANGES_PER_SET (RANGES_PER_SET)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .query (cur),
        .tin   (head),
        .tout  (chain[i])
      );
    end else begin : g_next
      src_rule_cell #(
        .IDX            (i),
        .RANGES_PER_SET (RANGES_PER_SET)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .query (cur),
        .tin   (chain[i-1]),
        .tout  (chain[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      searching  <= 1'b0;
      start      <= 1'b0;
      load_go    <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      rule_count <= '0;
    end else begin
      start   <= req_acc && is_classify;
      load_go <= req_acc && !is_classify;
      if (req_acc && is_classify) begin
        searching <= 1'b1;
      end else if (last.valid) begin
        searching <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        rule_count <= cfg_data;
      end
      // Pass a finished result to the output, or park it while the output is held.
      if (rsp_free) begin
        if (pend_valid) begin
          rsp_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          rsp_valid <= last.valid;
        end
      end else if (last.valid) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      cur <= req;
    end
    if (rsp_free) begin
      if (pend_valid) begin
        rsp <= pend;
      end else if (last.valid) begin
        rsp <= last.res;
      end
    end else if (last.valid) begin
      pend <= last.res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/src_checker.sv -----
// Port checker for the rule classifier, bound to the top level.
`default_nettype none

`include "service_rule_classifier_macros.svh"

module src_checker
  import src_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  `SRC_ASSERT_ALWAYS(a_reset_clears, rst |=> !rsp_valid, "result valid after reset")
  `SRC_ASSERT(a_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result moved")
  `SRC_ASSERT(a_miss_zero, rsp_valid && !rsp.matched |-> rsp.rule_number == 4'd0 && !rsp.swapped && rsp.server_port == 16'd0 && rsp.client_port == 16'd0, "miss with non-zero fields")
  `SRC_ASSERT(a_swap_needs_hit, rsp_valid && rsp.swapped |-> rsp.matched, "swap without a hit")

endmodule

bind service_rule_classifier src_checker u_src_checker (.*);

`default_nettype wire

// ----- tb/sv/service_rule_classifier_tb.sv -----
// Self-checking testbench for the service rule classifier: loads rules, classifies streams.
`timescale 1ns / 1ps

module service_rule_classifier_tb;
  import src_pkg::*;

  localparam int RULE_SLOTS     = 16;
  localparam int RANGES_PER_SET = 4;
  localparam int TABLE_RANGES   = RULE_SLOTS * RANGES_PER_SET;
  localparam int SETTLE_CYCLES  = 2 * (RULE_SLOTS + 1) + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int LONG_HOLD      = 300;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  service_rule_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow rule table and rule count
  logic [7:0]  rule_protos [RULE_SLOTS];
  logic [15:0] src_low     [TABLE_RANGES];
  logic [15:0] src_high    [TABLE_RANGES];
  logic [15:0] dst_low     [TABLE_RANGES];
  logic [15:0] dst_high    [TABLE_RANGES];
  logic [4:0]  rules_in_use;

  req_t pending_requests [$];
  rsp_t expected_verdicts [$];

  int mismatches    = 0;
  int results_taken = 0;
  int quiet_cycles  = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int hold_left     = 0;
  int holds_done    = 0;
  int pace_mode     = 0;
  int mode_left     = 0;
  int pace_tick     = 0;

  // Ports and protocols that the rules of one phase are built around
  int hot_ports  [8];
  int hot_protos [4];

  function automatic bit port_hits(input logic [15:0] port, input bit dst_side, input int rule);
    int base;
    logic [15:0] lo, hi;
    base = rule * RANGES_PER_SET;
    for (int k = 0; k < RANGES_PER_SET; k++) begin
      lo = dst_side ? dst_low[base + k] : src_low[base + k];
      hi = dst_side ? dst_high[base + k] : src_high[base + k];
      if (port >= lo && port <= hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t classify_stream(input req_t r);
    rsp_t verdict;
    int limit;
    bit rev;
    verdict = '0;
    limit = (rules_in_use > RULE_SLOTS) ? RULE_SLOTS : int'(rules_in_use);
    for (int i = 0; i < limit; i++) begin
      if (rule_protos[i] != r.protocol) continue;
      if (port_hits(r.first_port, 1'b0, i)) begin
        rev = 1'b1;
        if (!port_hits(r.second_port, 1'b1, i)) continue;
      end else if (port_hits(r.first_port, 1'b1, i)) begin
        rev = 1'b0;
        // ICMP never matches the forward way
        if (r.protocol == PROTO_ICMP) continue;
        if (!port_hits(r.second_port, 1'b0, i)) continue;
      end else begin
        continue;
      end
      if (rev && r.syn_only) continue;
      verdict.matched     = 1'b1;
      verdict.rule_number = i[3:0];
      if (rev && r.protocol != PROTO_ICMP) begin
        verdict.swapped     = 1'b1;
        verdict.server_port = r.second_port;
        verdict.client_port = r.first_port;
      end else begin
        verdict.server_port = r.first_port;
        verdict.client_port = r.second_port;
      end
      return verdict;
    end
    return verdict;
  endfunction

  function automatic int clamp_port(input int p);
    if (p < 0) return 0;
    if (p > 65535) return 65535;
    return p;
  endfunction

  function automatic int near_hot_port();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return clamp_port(hot_ports[$urandom_range(0, 7)] + int'($urandom_range(0, 6)) - 3);
  endfunction

  // Unused fields carry random bits so that the block is seen to ignore them
  function automatic req_t rule_load(input logic [1:0] op, input int idx, input int slot,
                                     input int lo, input int hi, input int proto);
    logic [95:0] noise;
    req_t r;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    r.cmd        = op;
    r.rule_index = idx[3:0];
    r.range_slot = slot[1:0];
    r.range_low  = lo[15:0];
    r.range_high = hi[15:0];
    r.protocol   = proto[7:0];
    return r;
  endfunction

  function automatic req_t stream(input int proto, input int p0, input int p1, input bit syn);
    logic [95:0] noise;
    req_t r;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    r.cmd         = CMD_CLASSIFY;
    r.protocol    = proto[7:0];
    r.first_port  = p0[15:0];
    r.second_port = p1[15:0];
    r.syn_only    = syn;
    return r;
  endfunction

  function automatic req_t random_rule_load();
    logic [1:0] op;
    int idx, lo, hi, c, proto;
    if ($urandom_range(0, 2) == 0) op = CMD_WR_PROTO;
    else op = $urandom_range(0, 1) ? CMD_WR_SRC : CMD_WR_DST;
    idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    proto = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : hot_protos[$urandom_range(0, 3)];
    case ($urandom_range(0, 5))
      0: begin
        lo = 0;
        hi = 65535;
      end
      1: begin
        // empty range: high below low
        lo = $urandom_range(1, 65535);
        hi = $urandom_range(0, lo - 1);
      end
      2: begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end
      default: begin
        c  = near_hot_port();
        lo = clamp_port(c - int'($urandom_range(0, 20)));
        hi = clamp_port(c + int'($urandom_range(0, 20)));
      end
    endcase
    return rule_load(op, idx, $urandom_range(0, 3), lo, hi, proto);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
  endtask

  // Hold until every request is in and every verdict is out, then let the row drain
  task automatic wait_idle();
    while (pending_requests.size() != 0 || req_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rules_in_use = value;
  endtask

  // Request driver
  always @(posedge clk) begin : drive_requests
    logic took;
    int at;
    if (!rst) begin
      took = req_valid && !req_stall;
      if (took) begin
        at = int'(req.rule_index) * RANGES_PER_SET + int'(req.range_slot);
        case (req.cmd)
          CMD_CLASSIFY: expected_verdicts.push_back(classify_stream(req));
          CMD_WR_PROTO: rule_protos[req.rule_index] = req.protocol;
          CMD_WR_SRC: begin
            src_low[at]  = req.range_low;
            src_high[at] = req.range_high;
          end
          CMD_WR_DST: begin
            dst_low[at]  = req.range_low;
            dst_high[at] = req.range_high;
          end
          default: begin
          end
        endcase
      end
      if (!req_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req       <= pending_requests.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern, with long hold-offs while requests keep coming
  always @(posedge clk) begin : pace_results
    logic next_stall;
    pace_tick++;
    if (rst) begin
      next_stall = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (holds_done < 2 && pending_requests.size() > 20 &&
                 results_taken > 20 + 150 * holds_done) begin
      hold_left  = LONG_HOLD;
      holds_done++;
      next_stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        pace_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (pace_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        default: next_stall = (pace_tick % 8) < 3;
      endcase
    end
    rsp_stall <= next_stall;
  end

  // Result checker
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_taken++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", rsp.server_port, 16'h0);
      end else begin
        want = expected_verdicts.pop_front();
        if (rsp.matched !== want.matched)
          report_mismatch("matched", 16'(rsp.matched), 16'(want.matched));
        if (rsp.rule_number !== want.rule_number)
          report_mismatch("rule_number", 16'(rsp.rule_number), 16'(want.rule_number));
        if (rsp.swapped !== want.swapped)
          report_mismatch("swapped", 16'(rsp.swapped), 16'(want.swapped));
        if (rsp.server_port !== want.server_port)
          report_mismatch("server_port", rsp.server_port, want.server_port);
        if (rsp.client_port !== want.client_port)
          report_mismatch("client_port", rsp.client_port, want.client_port);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("service_rule_classifier_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n_setup, n_traffic;
    for (int i = 0; i < RULE_SLOTS; i++) rule_protos[i] = '0;
    for (int i = 0; i < TABLE_RANGES; i++) begin
      src_low[i]  = EMPTY_LOW;
      src_high[i] = EMPTY_HIGH;
      dst_low[i]  = EMPTY_LOW;
      dst_high[i] = EMPTY_HIGH;
    end
    rules_in_use = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, no rules searched
    wait_idle();
    write_count(5'd0);
    pending_requests.push_back(stream(255, 65535, 65535, 1'b1));
    pending_requests.push_back(stream(0, 0, 1, 1'b0));

    // Directed rules, searched with the largest rule count
    wait_idle();
    write_count(5'd31);
    pending_requests.push_back(rule_load(CMD_WR_PROTO, 0, 0, 0, 0, PROTO_TCP));
    pending_requests.push_back(rule_load(CMD_WR_SRC, 0, 0, 1024, 65535, 0));
    pending_requests.push_back(rule_load(CMD_WR_DST, 0, 3, 80, 80, 0));
    pending_requests.push_back(rule_load(CMD_WR_PROTO, 1, 0, 0, 0, PROTO_ICMP));
    pending_requests.push_back(rule_load(CMD_WR_SRC, 1, 0, 8, 8, 0));
    pending_requests.push_back(rule_load(CMD_WR_DST, 1, 0, 0, 0, 0));
    pending_requests.push_back(rule_load(CMD_WR_PROTO, 15, 0, 0, 0, PROTO_UDP));
    pending_requests.push_back(rule_load(CMD_WR_SRC, 15, 3, 0, 65535, 0));
    pending_requests.push_back(rule_load(CMD_WR_DST, 15, 1, 53, 53, 0));
    pending_requests.push_back(rule_load(CMD_WR_DST, 15, 2, 200, 100, 0));
    pending_requests.push_back(stream(PROTO_TCP, 80, 5000, 1'b0));
    pending_requests.push_back(stream(PROTO_TCP, 80, 5000, 1'b1));
    pending_requests.push_back(stream(PROTO_TCP, 5000, 80, 1'b0));
    pending_requests.push_back(stream(PROTO_TCP, 5000, 80, 1'b1));
    pending_requests.push_back(stream(PROTO_ICMP, 8, 0, 1'b0));
    pending_requests.push_back(stream(PROTO_ICMP, 0, 8, 1'b0));
    pending_requests.push_back(stream(PROTO_UDP, 1000, 53, 1'b0));
    pending_requests.push_back(stream(PROTO_UDP, 150, 53, 1'b1));
    pending_requests.push_back(stream(PROTO_UDP, 150, 200, 1'b0));
    pending_requests.push_back(stream(PROTO_TCP, 65535, 80, 1'b0));
    pending_requests.push_back(stream(PROTO_TCP, 0, 65535, 1'b0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_count(5'd16);
        1: write_count(5'd1);
        2: write_count(5'($urandom_range(17, 31)));
        default: write_count(5'($urandom_range(0, 31)));
      endcase
      for (int k = 0; k < 8; k++)
        hot_ports[k] = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 65535 : 0)
                                                   : $urandom_range(0, 65535);
      hot_protos[0] = PROTO_ICMP;
      hot_protos[1] = PROTO_TCP;
      hot_protos[2] = PROTO_UDP;
      hot_protos[3] = $urandom_range(0, 255);

      // Build rules first, then mostly traffic aimed at them with stray loads
      n_setup = $urandom_range(6, 20);
      for (int k = 0; k < n_setup; k++) pending_requests.push_back(random_rule_load());
      n_traffic = $urandom_range(30, 70);
      for (int k = 0; k < n_traffic; k++) begin
        if ($urandom_range(0, 7) == 0)
          pending_requests.push_back(random_rule_load());
        else
          pending_requests.push_back(stream(
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                        : hot_protos[$urandom_range(0, 3)],
            near_hot_port(), near_hot_port(), ($urandom_range(0, 2) == 0)));
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("service_rule_classifier_tb: PASS");
    end else begin
      $display("service_rule_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/src_pkg.sv
rtl/src_rule_cell.sv
rtl/service_rule_classifier.sv
rtl/src_checker.sv
tb/sv/service_rule_classifier_tb.sv
